[rtl/png_scanline_unfilter_unpremultiply_top_macros.svh]
// Assertion macros shared by the filter reconstruction block.
`ifndef PNG_SCANLINE_UNFILTER_UNPREMULTIPLY_TOP_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_UNPREMULTIPLY_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define PLS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pls_pkg.sv]
// Shared constants and helpers for the scanline reconstruction block.
package pls_pkg;
	localparam int MAX_WIDTH  = 4096;
	localparam int LINE_DEPTH = MAX_WIDTH * 4;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int COL_W      = ADDR_W + 1;
	localparam int WIDTH_W    = 13;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int NUM_W      = 16;
	localparam int DIV_STEPS  = NUM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam logic [WIDTH_W+HEIGHT_W-1:0] PIXEL_LIMIT = 29'h4000000;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;
	localparam logic [7:0] FILT_MAX   = 8'd4;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		byte_t red;
		byte_t green;
		byte_t blue;
		byte_t alpha;
		logic  last_in_row;
		logic  last_in_image;
		logic  bad_filter;
	} pixel_t;

	function automatic byte_t paeth(input byte_t a, input byte_t b, input byte_t c);
		logic signed [9:0] pa, pb, pc;
		pa = $signed({2'b00, b}) - $signed({2'b00, c});
		pb = $signed({2'b00, a}) - $signed({2'b00, c});
		pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction
endpackage

[rtl/pls_in_if.sv]
// Byte stream channel into the block.
interface pls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	modport source (output valid, output raw_byte, input ready);
	modport sink (input valid, input raw_byte, output ready);
endinterface

[rtl/pls_out_if.sv]
// Pixel result channel out of the block.
interface pls_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_in_row;
	logic       last_in_image;
	logic       bad_filter;
	modport source (output valid, output red, output green, output blue, output alpha,
		output last_in_row, output last_in_image, output bad_filter, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input last_in_row, input last_in_image, input bad_filter, output ready);
endinterface

[rtl/pls_line_ram.sv]
// Previous-row line store: one write port, one registered read port.
module pls_line_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [pls_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic [pls_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata
);
	import pls_pkg::*;

	logic [7:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/pls_div.sv]
// Restoring divider, one quotient bit per cycle; low 8 quotient bits out.
module pls_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pls_pkg::NUM_W-1:0] num,
	input  logic [7:0]               den,
	output logic                     done,
	output logic [7:0]               quo
);
	import pls_pkg::*;

	logic [7:0]           rem_q;
	logic [NUM_W-1:0]     num_q;
	logic [7:0]           den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [8:0]           trial;
	logic                 fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign quo   = num_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			// remainder stays below den, so 8 bits hold it
			rem_q <= fits ? 8'(trial - {1'b0, den_q}) : trial[7:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end
endmodule

[rtl/png_scanline_unfilter_unpremultiply_top.sv]
// Usage: PNG filter reconstruction with BGRA->RGBA swap and un-premultiply.
// in_ch carries the inflated stream one byte per transfer: per row a filter
// byte, then width*4 sample bytes (B,G,R,A per pixel). out_ch gives one
// pixel per fourth sample byte, or one error result for a filter byte
// above 4 or an oversized image, after which the rest of that image is
// consumed silently. cfg_we/cfg_index/cfg_data write the width (index 0)
// and height (index 1); write them only while the block is idle.
// A filter byte, or a sample byte of a dropped image, is taken in the idle
// state; a filter byte that raises an error then passes through the emit
// state. A kept sample byte is taken while the line store is read, then
// reconstructed and written back in the calc state. The fourth byte of a
// pixel then loads the result in the emit state, after the three bit-serial
// divisions in the div state when alpha is strictly between 0 and 255.
// The result sits in an output register; a stalled receiver holds it
// while the next bytes are still taken, and the block only waits when a
// second result is ready before the first has been transferred.
// Reset clears all counters and flags and sets width and height to 1; the
// line store is not cleared (row 0 never reads it).
`include "png_scanline_unfilter_unpremultiply_top_macros.svh"
module png_scanline_unfilter_unpremultiply_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pls_pkg::CFG_DATA_W-1:0] cfg_data,
	pls_in_if.sink                        in_ch,
	pls_out_if.source                     out_ch
);
	import pls_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_EMIT} state_t;

	state_t               state_q;
	logic [WIDTH_W-1:0]   width_q;
	logic [HEIGHT_W-1:0]  height_q;
	logic [HEIGHT_W-1:0]  row_q;
	logic [COL_W-1:0]     col_q;
	logic [2:0]           filt_q;
	logic                 drop_q;
	byte_t                left_q [4];
	byte_t                ul_q [4];
	pixel_t               pix_q;
	pixel_t               out_q;
	logic                 out_valid_q;

	byte_t                byte_s1;
	logic [1:0]           ch_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic                 rowz_s1;
	logic                 rend_s1;
	logic                 limg_s1;

	logic [WIDTH_W-1:0]   w_eff;
	logic [HEIGHT_W-1:0]  h_eff;
	logic [COL_W-1:0]     row_bytes;
	logic                 row_wrap;
	logic [HEIGHT_W-1:0]  row_cur;
	logic                 drop_cur;
	logic [HEIGHT_W:0]    row_next;
	logic                 img_end;
	logic                 row_end;
	logic [COL_W-1:0]     col_m1;
	logic                 too_big;
	logic                 in_xfer;
	logic                 slot_free;

	byte_t                rdata;
	byte_t                up, left, ul, pred, recon;
	logic [8:0]           avg_sum;
	logic                 div_start;
	logic [NUM_W-1:0]     num_r, num_g, num_b;
	logic                 done_r, done_g, done_b;
	byte_t                q_r, q_g, q_b;

	assign w_eff = (width_q == '0) ? WIDTH_W'(1) :
		(width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q;
	assign h_eff     = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign row_bytes = {w_eff, 2'b00};
	assign row_wrap  = row_q >= h_eff;
	assign row_cur   = row_wrap ? '0 : row_q;
	assign drop_cur  = row_wrap ? 1'b0 : drop_q;
	assign row_next  = {1'b0, row_cur} + 1'b1;
	assign img_end   = row_next >= {1'b0, h_eff};
	assign row_end   = col_q >= row_bytes;
	assign col_m1    = col_q - 1'b1;
	assign too_big   = ({{HEIGHT_W{1'b0}}, w_eff} * {{WIDTH_W{1'b0}}, h_eff}) > PIXEL_LIMIT;

	assign in_ch.ready = state_q == S_IDLE;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;

	pls_line_ram u_ram (
		.clk   (clk),
		.we    (state_q == S_CALC),
		.waddr (addr_s1),
		.wdata (recon),
		.raddr (col_m1[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// reconstruction of one sample byte
	always_comb begin
		left    = left_q[ch_s1];
		ul      = ul_q[ch_s1];
		up      = rowz_s1 ? 8'h00 : rdata;
		avg_sum = {1'b0, left} + {1'b0, up};
		case (filt_q)
			FILT_SUB:   pred = left;
			FILT_UP:    pred = up;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth(left, up, ul);
			default:    pred = 8'h00;
		endcase
		recon = byte_s1 + pred;
	end

	assign div_start = state_q == S_CALC && ch_s1 == 2'd3 && recon != 8'h00 && recon != 8'hFF;
	// c*255 + a/2
	assign num_r = ({left_q[2], 8'h00} - {8'h00, left_q[2]}) + {9'd0, recon[7:1]};
	assign num_g = ({left_q[1], 8'h00} - {8'h00, left_q[1]}) + {9'd0, recon[7:1]};
	assign num_b = ({left_q[0], 8'h00} - {8'h00, left_q[0]}) + {9'd0, recon[7:1]};

	pls_div u_div_r (.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_r),
		.den(recon), .done(done_r), .quo(q_r));
	pls_div u_div_g (.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_g),
		.den(recon), .done(done_g), .quo(q_g));
	pls_div u_div_b (.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_b),
		.den(recon), .done(done_b), .quo(q_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WIDTH_W'(1);
			height_q    <= HEIGHT_W'(1);
			row_q       <= '0;
			col_q       <= '0;
			filt_q      <= FILT_NONE;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				left_q[k] <= '0;
				ul_q[k]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_EMIT && slot_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (col_q == '0) begin
							for (int k = 0; k < 4; k++) begin
								left_q[k] <= '0;
								ul_q[k]   <= '0;
							end
							row_q  <= row_cur;
							drop_q <= drop_cur;
							col_q  <= COL_W'(1);
							if (!drop_cur) begin
								if (in_ch.raw_byte > FILT_MAX || (row_cur == '0 && too_big)) begin
									drop_q  <= 1'b1;
									pix_q   <= '{red: 8'h00, green: 8'h00, blue: 8'h00,
										alpha: 8'h00, last_in_row: 1'b0,
										last_in_image: 1'b0, bad_filter: 1'b1};
									state_q <= S_EMIT;
								end else begin
									filt_q <= in_ch.raw_byte[2:0];
								end
							end
						end else begin
							if (!drop_cur) state_q <= S_CALC;
							if (row_end) begin
								col_q <= '0;
								if (img_end) begin
									row_q  <= '0;
									drop_q <= 1'b0;
								end else begin
									row_q  <= row_next[HEIGHT_W-1:0];
									drop_q <= drop_cur;
								end
							end else begin
								col_q  <= col_q + 1'b1;
								row_q  <= row_cur;
								drop_q <= drop_cur;
							end
						end
					end
				end
				S_CALC: begin
					left_q[ch_s1] <= recon;
					ul_q[ch_s1]   <= up;
					if (ch_s1 == 2'd3) begin
						pix_q.red           <= left_q[2];
						pix_q.green         <= left_q[1];
						pix_q.blue          <= left_q[0];
						pix_q.alpha         <= recon;
						pix_q.last_in_row   <= rend_s1;
						pix_q.last_in_image <= limg_s1;
						pix_q.bad_filter    <= 1'b0;
						state_q <= div_start ? S_DIV : S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (done_r) begin
						pix_q.red   <= q_r;
						pix_q.green <= q_g;
						pix_q.blue  <= q_b;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-byte stage and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_ch.raw_byte;
			ch_s1   <= col_m1[1:0];
			addr_s1 <= col_m1[ADDR_W-1:0];
			rowz_s1 <= row_cur == '0;
			rend_s1 <= row_end;
			limg_s1 <= row_end && img_end;
		end
		if (state_q == S_EMIT && slot_free) out_q <= pix_q;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.red           = out_q.red;
	assign out_ch.green         = out_q.green;
	assign out_ch.blue          = out_q.blue;
	assign out_ch.alpha         = out_q.alpha;
	assign out_ch.last_in_row   = out_q.last_in_row;
	assign out_ch.last_in_image = out_q.last_in_image;
	assign out_ch.bad_filter    = out_q.bad_filter;

	`PLS_ASSERT_SAME(a_err_zero, clk, arst_n, out_ch.valid && out_ch.bad_filter, out_ch.red == 8'h00 && out_ch.green == 8'h00 && out_ch.blue == 8'h00 && out_ch.alpha == 8'h00 && !out_ch.last_in_row && !out_ch.last_in_image, "error result carries pixel data")
	`PLS_ASSERT_SAME(a_div_lockstep, clk, arst_n, done_r, done_g && done_b, "dividers out of step")
	`PLS_ASSERT_NEXT(a_emit_loads, clk, arst_n, state_q == S_EMIT && slot_free, out_ch.valid && state_q == S_IDLE, "result not loaded into output register")
endmodule

[tb/pls_checker.sv]
// Scoreboard for the scanline unfilter block: mirrors registers, predicts pixels, compares.
module pls_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pls_pkg::CFG_DATA_W-1:0] cfg_data,
	pls_in_if                              in_ch,
	pls_out_if                             out_ch,
	output int                             fails,
	output int                             pending
);
	import pls_pkg::*;

	byte_t        prev_row [LINE_DEPTH];
	byte_t        left_px [4];
	byte_t        upleft_px [4];
	int unsigned  row_cnt;
	int unsigned  col_cnt;
	logic [2:0]   cur_filter;
	logic         skip_image;
	int unsigned  width_reg;
	int unsigned  height_reg;
	pixel_t       pixel_q [$];

	function automatic int unsigned paeth_pick(int a, int b, int c);
		int p, da, db, dc;
		p  = a + b - c;
		da = (p > a) ? p - a : a - p;
		db = (p > b) ? p - b : b - p;
		dc = (p > c) ? p - c : c - p;
		if (da <= db && da <= dc)
			return a;
		return (db <= dc) ? b : c;
	endfunction

	function automatic byte_t unpremul(int unsigned c, int unsigned a);
		int unsigned v;
		v = (c * 255 + a / 2) / a;
		return v[7:0];
	endfunction

	task automatic unfilter_byte(input byte_t b);
		int unsigned w, h, row_len, idx, ch, lft, up, ul, pred;
		byte_t       x, rd, gr, bl, al;
		pixel_t      px;
		logic        bad;
		w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		row_len = w * 4;
		if (row_cnt >= h) begin
			row_cnt = 0;
			skip_image = 1'b0;
		end
		if (col_cnt == 0) begin
			for (int k = 0; k < 4; k++) begin
				left_px[k] = '0;
				upleft_px[k] = '0;
			end
			if (!skip_image) begin
				bad = b > FILT_MAX;
				if (row_cnt == 0 && longint'(w) * longint'(h) > longint'(PIXEL_LIMIT))
					bad = 1'b1;
				if (bad) begin
					skip_image = 1'b1;
					px = '0;
					px.bad_filter = 1'b1;
					pixel_q = {pixel_q, px};
				end else begin
					cur_filter = b[2:0];
				end
			end
			col_cnt = 1;
			return;
		end
		idx = (col_cnt - 1) % LINE_DEPTH;
		ch = idx % 4;
		if (!skip_image) begin
			lft = left_px[ch];
			up  = (row_cnt > 0) ? prev_row[idx] : 0;
			ul  = upleft_px[ch];
			case (cur_filter)
				FILT_SUB:   pred = lft;
				FILT_UP:    pred = up;
				FILT_AVG:   pred = (lft + up) >> 1;
				FILT_PAETH: pred = paeth_pick(lft, up, ul);
				default:    pred = 0;
			endcase
			x = byte_t'(b + pred);
			upleft_px[ch] = byte_t'(up);
			left_px[ch] = x;
			prev_row[idx] = x;
			if (ch == 3) begin
				bl = left_px[0];
				gr = left_px[1];
				rd = left_px[2];
				al = left_px[3];
				if (al > 0 && al < 255) begin
					rd = unpremul(rd, al);
					gr = unpremul(gr, al);
					bl = unpremul(bl, al);
				end
				px.red = rd;
				px.green = gr;
				px.blue = bl;
				px.alpha = al;
				px.last_in_row = col_cnt >= row_len;
				px.last_in_image = (col_cnt >= row_len) && (row_cnt + 1 >= h);
				px.bad_filter = 1'b0;
				pixel_q = {pixel_q, px};
			end
		end
		if (col_cnt >= row_len) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= h) begin
				row_cnt = 0;
				skip_image = 1'b0;
			end
		end else begin
			col_cnt++;
		end
	endtask

	task automatic report(input string field, input int got, input int want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				left_px[k] = '0;
				upleft_px[k] = '0;
			end
			row_cnt = 0;
			col_cnt = 0;
			cur_filter = FILT_NONE;
			skip_image = 1'b0;
			width_reg = 1;
			height_reg = 1;
			pixel_q.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data[WIDTH_W-1:0];
				else if (cfg_index == REG_HEIGHT)
					height_reg = cfg_data[HEIGHT_W-1:0];
			end
			if (in_ch.valid && in_ch.ready)
				unfilter_byte(in_ch.raw_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (pixel_q.size() == 0) begin
					report("unexpected pixel transfer", 1, 0);
				end else begin
					want = pixel_q.pop_front();
					if (out_ch.red !== want.red)
						report("red", out_ch.red, want.red);
					if (out_ch.green !== want.green)
						report("green", out_ch.green, want.green);
					if (out_ch.blue !== want.blue)
						report("blue", out_ch.blue, want.blue);
					if (out_ch.alpha !== want.alpha)
						report("alpha", out_ch.alpha, want.alpha);
					if (out_ch.last_in_row !== want.last_in_row)
						report("last_in_row", out_ch.last_in_row, want.last_in_row);
					if (out_ch.last_in_image !== want.last_in_image)
						report("last_in_image", out_ch.last_in_image, want.last_in_image);
					if (out_ch.bad_filter !== want.bad_filter)
						report("bad_filter", out_ch.bad_filter, want.bad_filter);
				end
			end
		end
		pending = pixel_q.size();
	end
endmodule

[tb/tb_top.sv]
// Top of the scanline unfilter testbench: clock, reset, stimulus, stalls and verdict.
module tb_top;
	import pls_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;
	int                    bytes_sent;
	int                    idle_cycles;

	pls_in_if  in_ch();
	pls_out_if out_ch();

	png_scanline_unfilter_unpremultiply_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	pls_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.fails(fails), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: random stall before each pixel transfer
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, 14);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	task automatic send_byte(input byte_t b);
		int gap;
		gap = $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// wait until every pixel has arrived and the block has gone quiet
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input int w, input int h);
		drain();
		write_reg(REG_WIDTH, w[15:0]);
		write_reg(REG_HEIGHT, h[15:0]);
	endtask

	// one image at the current geometry; bad_pct percent of rows carry an illegal filter
	task automatic send_image(input int w, input int h, input int bad_pct);
		byte_t f, b;
		for (int r = 0; r < h; r++) begin
			if ($urandom_range(1, 100) <= bad_pct)
				f = $urandom_range(0, 1) ? byte_t'(FILT_MAX + 1) : byte_t'($urandom_range(5, 255));
			else
				f = byte_t'($urandom_range(FILT_NONE, FILT_PAETH));
			send_byte(f);
			for (int j = 0; j < w * 4; j++) begin
				b = $urandom;
				// push alpha toward the fully opaque and fully clear cases
				if (j % 4 == 3 && f == FILT_NONE)
					case ($urandom_range(0, 3))
						0: b = 8'h00;
						1: b = 8'hFF;
						default: ;
					endcase
				send_byte(b);
			end
		end
	endtask

	initial begin
		int w, h;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.raw_byte = '0;
		out_ch.ready = 1'b0;
		bytes_sent = 0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// each filter in turn down a one-pixel column, extreme bytes
		set_geometry(1, 5);
		send_byte(byte_t'(FILT_NONE));
		send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80); send_byte(8'h7F);
		send_byte(byte_t'(FILT_SUB));
		send_byte(8'h01); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01);
		send_byte(byte_t'(FILT_UP));
		send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF); send_byte(8'h80);
		send_byte(byte_t'(FILT_AVG));
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00);
		send_byte(byte_t'(FILT_PAETH));
		send_byte(8'h10); send_byte(8'hF0); send_byte(8'h00); send_byte(8'hFF);
		// illegal filter in the second row drops the rest of the image
		set_geometry(1, 3);
		send_byte(byte_t'(FILT_NONE));
		send_byte(8'h20); send_byte(8'h40); send_byte(8'h60); send_byte(8'h01);
		send_byte(8'hFF);
		repeat (4) send_byte(8'h55);
		send_byte(byte_t'(FILT_PAETH));
		repeat (4) send_byte(8'hAA);
		// oversized image: error on the first filter byte, then shrink to end it
		set_geometry(4096, 16385);
		send_byte(byte_t'(FILT_NONE));
		set_geometry(1, 1);
		repeat (4) send_byte(8'hC3);
		// zero width and height act as one, width bits above the low 13 ignored
		set_geometry(0, 0);
		send_image(1, 1, 0);
		set_geometry(16'hE003, 2);
		send_image(3, 2, 0);

		// random geometries, mostly small
		while (bytes_sent < 1900) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			set_geometry(w, h);
			repeat ($urandom_range(1, 3)) send_image(w, h, 8);
		end

		// width above the maximum clamps to it: exactly at the pixel limit, no error;
		// then shrink the row to finish the image
		set_geometry(16'h1FFF, 16384);
		send_byte(byte_t'(FILT_NONE));
		set_geometry(1, 1);
		repeat (4) send_byte(8'h5A);
		set_geometry(2, 65535);
		send_byte(byte_t'(FILT_MAX + 1));
		set_geometry(1, 1);
		send_image(1, 1, 0);

		drain();
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_in_if.sv
rtl/pls_out_if.sv
rtl/pls_line_ram.sv
rtl/pls_div.sv
rtl/png_scanline_unfilter_unpremultiply_top.sv
tb/pls_checker.sv
tb/tb_top.sv
